### rtl/core/spsp_pkg.sv
// Package for the pitch shift sample player: sizes, codes, state names and
// the structs passed between the sequencer, the modulo unit and the CSR block.
// No dependencies.
package spsp_pkg;

   localparam int SAMPLE_WORDS = 65536;
   localparam int MAX_CHANNELS = 2;
   localparam int SAMPLE_BITS  = 16;

   localparam int ADDR_BITS  = $clog2(SAMPLE_WORDS);
   localparam int CHAN_BITS  = 1;
   localparam int FRAME_BITS = 16;
   localparam int POS_BITS   = 32;
   localparam int FRAC_BITS  = 16;
   localparam int SPEED_BITS = 20;
   localparam int CCNT_BITS  = 2;

   // modulo unit: dividend one bit wider than a frame number
   localparam int MOD_BITS = FRAME_BITS + 1;
   localparam int MOD_CNT_BITS = $clog2(MOD_BITS);

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_SPEED       = 3'd0;
   localparam logic [2:0] REG_LOOP_ENABLE = 3'd1;
   localparam logic [2:0] REG_HALT_AT_END = 3'd2;
   localparam logic [2:0] REG_CHAN_COUNT  = 3'd3;
   localparam logic [2:0] REG_SOUND_FRAMES = 3'd4;

   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_RESTART = 2'd1;
   localparam logic [1:0] CMD_RENDER  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MOD_K,
      S_RD0,
      S_RD1,
      S_MUL,
      S_SUM,
      S_OUT,
      S_ADV,
      S_MOD_P
   } state_type;

   typedef struct packed {
      logic [SPEED_BITS-1:0] speed;
      logic                  loop_enable;
      logic                  halt_at_end;
      logic [CCNT_BITS-1:0]  channel_count;
      logic [FRAME_BITS-1:0] sound_frames;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      logic [MOD_BITS-1:0]   dividend;
      logic [FRAME_BITS-1:0] divisor;
   } mod_ctrl_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [FRAME_BITS-1:0] remainder;
   } mod_stat_type;

endpackage

### rtl/core/spsp_if.sv
// Handshake channels of the sample player: command items in, sample items out.
// Depends on spsp_pkg.
interface spsp_req_if;
   import spsp_pkg::*;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    command;
   logic [ADDR_BITS-1:0]          sample_addr;
   logic signed [SAMPLE_BITS-1:0] sample_value;

   modport source (output valid, command, sample_addr, sample_value, input ready);
   modport sink (input valid, command, sample_addr, sample_value, output ready);
endinterface

interface spsp_rsp_if;
   import spsp_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic [CHAN_BITS-1:0]          channel_index;
   logic                          last_of_frame;
   logic                          finished;

   modport source (output valid, sample_out, channel_index, last_of_frame, finished,
                   input ready);
   modport sink (input valid, sample_out, channel_index, last_of_frame, finished,
                 output ready);
endinterface

### rtl/core/spsp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module spsp_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);
   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/core/spsp_mod_unit.sv
// Shared restoring modulo unit, one remainder bit per cycle.
// Depends on spsp_pkg.
module spsp_mod_unit
   import spsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  mod_ctrl_type ctrl,
   output mod_stat_type stat
);
   localparam logic [MOD_CNT_BITS-1:0] LAST_STEP = MOD_CNT_BITS'(MOD_BITS - 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [MOD_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [FRAME_BITS-1:0]   rem_ff, rem_in;
   logic [MOD_BITS-1:0]     dvd_ff, dvd_in;
   logic [FRAME_BITS-1:0]   dvs_ff, dvs_in;
   logic [FRAME_BITS:0]     shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff, dvd_ff[MOD_BITS-1]};
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = ctrl.dividend;
         dvs_in  = ctrl.divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits a frame number
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = FRAME_BITS'(shifted - {1'b0, dvs_ff});
         end else begin
            rem_in = shifted[FRAME_BITS-1:0];
         end
         dvd_in = {dvd_ff[MOD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy      = busy_ff;
   assign stat.done      = done_ff;
   assign stat.remainder = rem_ff;
endmodule

### rtl/core/spsp_csr.sv
// APB-style register block: speed, looping, halting, channel count, length.
// Depends on spsp_pkg.
module spsp_csr
   import spsp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);
   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign reg_idx = paddr[CSR_ADDR_BITS-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_SPEED:        cfg_in.speed         = pwdata[SPEED_BITS-1:0];
            REG_LOOP_ENABLE:  cfg_in.loop_enable   = pwdata[0];
            REG_HALT_AT_END:  cfg_in.halt_at_end   = pwdata[0];
            REG_CHAN_COUNT:   cfg_in.channel_count = pwdata[CCNT_BITS-1:0];
            REG_SOUND_FRAMES: cfg_in.sound_frames  = pwdata[FRAME_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SPEED:        prdata = CSR_DATA_BITS'(cfg_ff.speed);
         REG_LOOP_ENABLE:  prdata = CSR_DATA_BITS'(cfg_ff.loop_enable);
         REG_HALT_AT_END:  prdata = CSR_DATA_BITS'(cfg_ff.halt_at_end);
         REG_CHAN_COUNT:   prdata = CSR_DATA_BITS'(cfg_ff.channel_count);
         REG_SOUND_FRAMES: prdata = CSR_DATA_BITS'(cfg_ff.sound_frames);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed         <= SPEED_BITS'(65536);
         cfg_ff.loop_enable   <= 1'b0;
         cfg_ff.halt_at_end   <= 1'b1;
         cfg_ff.channel_count <= CCNT_BITS'(2);
         cfg_ff.sound_frames  <= FRAME_BITS'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

### rtl/core/pitch_shift_sample_player_top.sv
// Top level of the pitch shift sample player: sequencer, interpolation datapath,
// sample RAM, shared modulo unit and CSR block. Depends on spsp_pkg, spsp_if,
// spsp_ram, spsp_mod_unit and spsp_csr.

// One item at a time. A write or restart item is done when it is accepted. A
// render item first reduces the frame number modulo the sound length in the
// shared modulo unit, then for each channel does two RAM reads, a multiply, a
// sum and the output hand-off (which waits while the sink stalls), then
// advances the position, with another pass through the modulo unit when a
// looping position wraps. A frame past the end of a non-looping sound gives
// silence. The sample RAM has no reset; only written words read back.
module pitch_shift_sample_player_top
   import spsp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   spsp_req_if.sink                 req_bus,
   spsp_rsp_if.source               rsp_bus,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);
   cfg_type      cfg;
   mod_ctrl_type mod_ctrl;
   mod_stat_type mod_stat;

   state_type state_ff, state_in;

   logic [POS_BITS-1:0]           pos_ff, pos_in;
   logic [FRAME_BITS-1:0]         f0_ff, f0_in;
   logic [FRAME_BITS-1:0]         f1_ff, f1_in;
   logic [CHAN_BITS-1:0]          chan_ff, chan_in;
   logic                          playing_ff, playing_in;
   logic signed [SAMPLE_BITS-1:0] v0_ff, v0_in;
   logic signed [33:0]            prod_ff, prod_in;
   logic [FRAC_BITS-1:0]          low_ff, low_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic [CHAN_BITS-1:0]          rsp_chan_ff, rsp_chan_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_fin_ff, rsp_fin_in;

   logic [FRAME_BITS-1:0]         frames;
   logic                          two_chan;
   logic                          chan_is_last;
   logic                          accept;
   logic                          play_now;
   logic [FRAME_BITS:0]           f1_wide;
   logic [ADDR_BITS-1:0]          rd_addr;
   logic [ADDR_BITS-1:0]          addr0, addr1;
   logic [SAMPLE_BITS-1:0]        rd_data;
   logic signed [SAMPLE_BITS:0]   diff;
   logic signed [33:0]            tsum;
   logic signed [17:0]            quot;
   logic [POS_BITS:0]             p_next;
   logic [POS_BITS:0]             p_dec;
   logic [POS_BITS:0]             dur;

   spsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   spsp_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .ctrl  (mod_ctrl),
      .stat  (mod_stat)
   );

   spsp_ram #(
      .ADDR_W (ADDR_BITS),
      .DATA_W (SAMPLE_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (accept && (req_bus.command == CMD_WRITE)),
      .wr_addr (req_bus.sample_addr),
      .wr_data (req_bus.sample_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign frames       = (cfg.sound_frames == '0) ? FRAME_BITS'(1) : cfg.sound_frames;
   assign two_chan     = (cfg.channel_count >= CCNT_BITS'(MAX_CHANNELS));
   assign chan_is_last = two_chan ? (chan_ff == CHAN_BITS'(1)) : 1'b1;
   assign dur          = {1'b0, frames, {FRAC_BITS{1'b0}}};
   assign accept       = req_bus.valid && req_bus.ready;
   assign play_now     = cfg.loop_enable || (pos_ff[POS_BITS-1:FRAC_BITS] < frames);
   assign f1_wide      = {1'b0, mod_stat.remainder} + 1'b1;

   // interleaved word address: frame * channels + channel, wrapped to the RAM
   assign addr0 = two_chan ? {f0_ff[ADDR_BITS-2:0], chan_ff} : f0_ff;
   assign addr1 = two_chan ? {f1_ff[ADDR_BITS-2:0], chan_ff} : f1_ff;
   assign rd_addr = (state_ff == S_RD1) ? addr1 : addr0;

   assign diff = $signed({rd_data[SAMPLE_BITS-1], rd_data}) -
                 $signed({v0_ff[SAMPLE_BITS-1], v0_ff});
   assign tsum = $signed({{2{v0_ff[SAMPLE_BITS-1]}}, v0_ff, {FRAC_BITS{1'b0}}}) + prod_ff;
   // truncate toward zero: round the arithmetic shift up for a negative inexact sum
   assign quot = tsum[33:FRAC_BITS] +
                 18'((tsum[33] && (tsum[FRAC_BITS-1:0] != '0)) ? 1 : 0);
   assign p_next = {1'b0, pos_ff} + (POS_BITS+1)'(cfg.speed);
   assign p_dec  = p_next - 1'b1;

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      f0_in         = f0_ff;
      f1_in         = f1_ff;
      chan_in       = chan_ff;
      playing_in    = playing_ff;
      v0_in         = v0_ff;
      prod_in       = prod_ff;
      low_in        = low_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_fin_in    = rsp_fin_ff;
      mod_ctrl.start    = 1'b0;
      mod_ctrl.dividend = {1'b0, pos_ff[POS_BITS-1:FRAC_BITS]};
      mod_ctrl.divisor  = frames;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_bus.command)
                  CMD_RESTART: pos_in = '0;
                  CMD_RENDER: begin
                     chan_in    = '0;
                     playing_in = play_now;
                     if (play_now) begin
                        mod_ctrl.start = 1'b1;
                        state_in       = S_MOD_K;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_sample_in = '0;
                        rsp_chan_in   = '0;
                        rsp_last_in   = !two_chan;
                        rsp_fin_in    = cfg.halt_at_end;
                        state_in      = S_OUT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MOD_K: begin
            if (mod_stat.done) begin
               f0_in    = mod_stat.remainder;
               f1_in    = (f1_wide == {1'b0, frames}) ? '0 : f1_wide[FRAME_BITS-1:0];
               state_in = S_RD0;
            end
         end
         S_RD0: state_in = S_RD1;
         S_RD1: begin
            v0_in    = rd_data;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = $signed({1'b0, pos_ff[FRAC_BITS-1:0]}) * diff;
            state_in = S_SUM;
         end
         S_SUM: begin
            rsp_valid_in  = 1'b1;
            rsp_sample_in = quot[SAMPLE_BITS-1:0];
            rsp_chan_in   = chan_ff;
            rsp_last_in   = chan_is_last;
            rsp_fin_in    = 1'b0;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (rsp_bus.ready) begin
               rsp_valid_in = 1'b0;
               if (!chan_is_last) begin
                  chan_in = chan_ff + 1'b1;
                  if (playing_ff) begin
                     state_in = S_RD0;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_sample_in = '0;
                     rsp_chan_in   = chan_ff + 1'b1;
                     rsp_last_in   = 1'b1;
                     rsp_fin_in    = cfg.halt_at_end;
                  end
               end else begin
                  state_in = playing_ff ? S_ADV : S_IDLE;
               end
            end
         end
         S_ADV: begin
            if (cfg.loop_enable && (p_next > dur)) begin
               // wrap into (0, D]: reduce the integer part of p-1, keep its fraction
               mod_ctrl.start    = 1'b1;
               mod_ctrl.dividend = p_dec[POS_BITS:FRAC_BITS];
               low_in            = p_dec[FRAC_BITS-1:0];
               state_in          = S_MOD_P;
            end else begin
               pos_in   = p_next[POS_BITS] ? '1 : p_next[POS_BITS-1:0];
               state_in = S_IDLE;
            end
         end
         S_MOD_P: begin
            if (mod_stat.done) begin
               pos_in   = {mod_stat.remainder, low_ff} + 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      f0_ff         <= f0_in;
      f1_ff         <= f1_in;
      chan_ff       <= chan_in;
      playing_ff    <= playing_in;
      v0_ff         <= v0_in;
      prod_ff       <= prod_in;
      low_ff        <= low_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_fin_ff    <= rsp_fin_in;
   end

   assign req_bus.ready         = (state_ff == S_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.sample_out    = rsp_sample_ff;
   assign rsp_bus.channel_index = rsp_chan_ff;
   assign rsp_bus.last_of_frame = rsp_last_ff;
   assign rsp_bus.finished      = rsp_fin_ff;

   // a pending result only exists in the output hand-off state
   a_rsp_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (state_ff == S_OUT))
      else $error("result valid outside output state");

   // no new item while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("input ready while result pending");

   // modulo results arrive only while the sequencer waits for them
   a_mod_done: assert property (@(posedge clock) disable iff (reset)
      mod_stat.done |-> ((state_ff == S_MOD_K) || (state_ff == S_MOD_P)))
      else $error("modulo done outside wait state");

   // a silent frame carries zero samples
   a_silence: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !playing_ff) |-> (rsp_bus.sample_out == '0))
      else $error("silent frame with nonzero sample");
endmodule

### bench/pitch_shift_sample_player_top_test.sv
// Self-checking bench for pitch_shift_sample_player_top: drives command items and
// CSR writes, predicts every interpolated sample item in a scoreboard class.
// Depends on spsp_pkg, spsp_if and the RTL of the sample player.
module pitch_shift_sample_player_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import spsp_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS  = 1250;
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam longint POS_MAX   = 64'h0000_0000_FFFF_FFFF;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [CHAN_BITS-1:0]          chan;
      logic                          last;
      logic                          fin;
   } out_sample_t;

   class frame_predictor;
      logic signed [SAMPLE_BITS-1:0] words [0:SAMPLE_WORDS-1];
      bit                            loaded [0:SAMPLE_WORDS-1];
      logic [POS_BITS-1:0]           position;
      logic [SPEED_BITS-1:0]         speed;
      bit                            loop_on;
      bit                            halt_on;
      logic [CCNT_BITS-1:0]          chan_reg;
      logic [FRAME_BITS-1:0]         frames_reg;
      out_sample_t                   due_samples[$];
      int                            errors;

      function new();
         position   = '0;
         speed      = 20'h10000;
         loop_on    = 1'b0;
         halt_on    = 1'b1;
         chan_reg   = 2'd2;
         frames_reg = 16'd1;
         errors     = 0;
      endfunction

      function int unsigned active_chans();
         if (chan_reg == 0) return 1;
         if (chan_reg > MAX_CHANNELS) return MAX_CHANNELS;
         return chan_reg;
      endfunction

      function int unsigned frame_total();
         return (frames_reg == 0) ? 1 : frames_reg;
      endfunction

      function bit is_playing();
         return loop_on || (longint'(position) < (longint'(frame_total()) << 16));
      endfunction

      // word of channel c in frame k+off, frame taken modulo the sound length
      function int unsigned frame_word(int unsigned off, int unsigned c);
         longint unsigned k;
         k = position >> 16;
         return ((k + off) % frame_total() * active_chans() + c) % SAMPLE_WORDS;
      endfunction

      function int unsigned sound_word(int unsigned r);
         return (r % (frame_total() * active_chans())) % SAMPLE_WORDS;
      endfunction

      // first word the next frame would read that has never been written, else -1
      function int next_missing();
         if (!is_playing()) return -1;
         for (int unsigned c = 0; c < active_chans(); c++) begin
            if (!loaded[frame_word(0, c)]) return frame_word(0, c);
            if (!loaded[frame_word(1, c)]) return frame_word(1, c);
         end
         return -1;
      endfunction

      function void set_reg(logic [2:0] idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            REG_SPEED:        speed = val[SPEED_BITS-1:0];
            REG_LOOP_ENABLE:  loop_on = val[0];
            REG_HALT_AT_END:  halt_on = val[0];
            REG_CHAN_COUNT:   chan_reg = val[CCNT_BITS-1:0];
            REG_SOUND_FRAMES: frames_reg = val[FRAME_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void render_frame();
         out_sample_t s;
         longint      v0, v1, t, p, dur, frac;
         int unsigned nch;
         bit          playing;
         nch     = active_chans();
         playing = is_playing();
         dur     = longint'(frame_total()) << 16;
         frac    = position[FRAC_BITS-1:0];
         for (int unsigned c = 0; c < nch; c++) begin
            t = 0;
            if (playing) begin
               v0 = words[frame_word(0, c)];
               v1 = words[frame_word(1, c)];
               // signed division truncates toward zero
               t = (v0 * 65536 + frac * (v1 - v0)) / 65536;
            end
            s.sample = t[SAMPLE_BITS-1:0];
            s.chan   = c[CHAN_BITS-1:0];
            s.last   = (c + 1 == nch);
            s.fin    = playing ? 1'b0 : halt_on;
            due_samples.push_back(s);
         end
         if (playing) begin
            p = longint'(position) + longint'(speed);
            if (loop_on && p > dur) p = (p - 1) % dur + 1;
            if (p > POS_MAX) p = POS_MAX;
            position = p[POS_BITS-1:0];
         end
      endfunction

      function void note_command(logic [1:0] cmd, logic [ADDR_BITS-1:0] addr,
                                 logic signed [SAMPLE_BITS-1:0] val);
         case (cmd)
            CMD_WRITE: begin
               words[addr]  = val;
               loaded[addr] = 1'b1;
            end
            CMD_RESTART: position = '0;
            CMD_RENDER:  render_frame();
            default: ;
         endcase
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
         errors++;
      endtask

      task check_sample(out_sample_t got);
         out_sample_t want;
         if (due_samples.size() == 0) begin
            report_mismatch("sample item with none expected", got.sample, 0);
            return;
         end
         want = due_samples.pop_front();
         if (got.sample !== want.sample) report_mismatch("sample_out", got.sample, want.sample);
         if (got.chan !== want.chan) report_mismatch("channel_index", got.chan, want.chan);
         if (got.last !== want.last) report_mismatch("last_of_frame", got.last, want.last);
         if (got.fin !== want.fin) report_mismatch("finished", got.fin, want.fin);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   spsp_req_if req_bus();
   spsp_rsp_if rsp_bus();

   frame_predictor board;
   int items_sent = 0;
   int item_goal  = 0;
   bit sender_steady = 1'b0;

   pitch_shift_sample_player_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'h8000;
      if (r < 20) return 16'h7FFF;
      if (r < 25) return 16'h0000;
      if (r < 30) return 16'hFFFF;
      return $urandom_range(0, 65535);
   endfunction

   function automatic logic [ADDR_BITS-1:0] rand_word();
      return $urandom_range(0, 65535);
   endfunction

   task automatic send_item(input logic [1:0] cmd, input logic [ADDR_BITS-1:0] addr,
                            input logic signed [SAMPLE_BITS-1:0] val);
      int gap;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.command      <= cmd;
      req_bus.sample_addr  <= addr;
      req_bus.sample_value <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_command(cmd, addr, val);
      if (cmd != CMD_UNUSED) items_sent++;
   endtask

   // load any sound word the frame is about to read, then render it
   task automatic play_frame();
      int miss;
      for (miss = board.next_missing(); miss >= 0; miss = board.next_missing())
         send_item(CMD_WRITE, miss[ADDR_BITS-1:0], pick_sample());
      send_item(CMD_RENDER, rand_word(), rand_word());
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (board.due_samples.size() != 0);
   endtask

   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // back-to-back writes keep psel high and drop penable for the setup cycle
   task automatic csr_write(input logic [2:0] idx, input logic [CSR_DATA_BITS-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.set_reg(idx, val);
   endtask

   task automatic apply_settings(input logic [SPEED_BITS-1:0] spd, input logic loop_en,
                                 input logic halt_en, input logic [CCNT_BITS-1:0] chans,
                                 input logic [FRAME_BITS-1:0] frames);
      csr_write(REG_SPEED, spd);
      csr_write(REG_LOOP_ENABLE, loop_en);
      csr_write(REG_HALT_AT_END, halt_en);
      csr_write(REG_CHAN_COUNT, chans);
      csr_write(REG_SOUND_FRAMES, frames);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic directed_part();
      // reset settings: one stereo frame, unit speed, no loop, halt on
      send_item(CMD_WRITE, 16'h0000, 16'h7FFF);
      send_item(CMD_WRITE, 16'h0001, 16'h8000);
      send_item(CMD_WRITE, 16'hFFFF, 16'hFFFF);
      send_item(CMD_UNUSED, 16'hFFFF, 16'h7FFF);
      play_frame();
      play_frame();   // past the end: silence with finished
      send_item(CMD_RESTART, 16'h0000, 16'h0000);
      play_frame();
      settle();
      // looping at 0.75: fractional blends, last frame blends into frame zero
      apply_settings(20'h0C000, 1'b1, 1'b0, 2'd2, 16'd3);
      send_item(CMD_WRITE, 16'd2, 16'h8000);
      send_item(CMD_WRITE, 16'd3, 16'h7FFF);
      send_item(CMD_WRITE, 16'd4, 16'h0000);
      send_item(CMD_WRITE, 16'd5, 16'hFFFF);
      send_item(CMD_RESTART, 16'hFFFF, 16'hFFFF);
      repeat (5) play_frame();
      settle();
      // zero speed, zero channels and zero length
      apply_settings(20'h00000, 1'b0, 1'b1, 2'd0, 16'd0);
      send_item(CMD_RESTART, 16'h0000, 16'h0000);
      repeat (2) play_frame();
      settle();
      // channel count above range, top speed, end without halt
      apply_settings(20'hFFFFF, 1'b0, 1'b0, 2'd3, 16'd2);
      send_item(CMD_RESTART, 16'h5555, 16'hAAAA);
      repeat (2) play_frame();
   endtask

   task automatic random_phase();
      int unsigned           r, len, n;
      logic [SPEED_BITS-1:0] spd;
      logic [FRAME_BITS-1:0] frm;
      logic [CCNT_BITS-1:0]  chn;
      settle();
      r = $urandom_range(0, 99);
      if (r < 25) spd = 20'h10000;
      else if (r < 45) spd = $urandom_range(1, 20'h20000);
      else if (r < 60) spd = $urandom_range(0, 20'hFFFFF);
      else if (r < 70) spd = 20'h00000;
      else if (r < 80) spd = 20'hFFFFF;
      else if (r < 90) spd = $urandom_range(1, 20'h00400);
      else spd = $urandom_range(20'h10000, 20'h30000);
      r = $urandom_range(0, 99);
      if (r < 50) frm = $urandom_range(1, 6);
      else if (r < 75) frm = $urandom_range(7, 64);
      else if (r < 83) frm = 16'd0;
      else if (r < 89) frm = 16'd32768;
      else if (r < 95) frm = rand_word();
      else frm = 16'hFFFF;
      chn = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 2) : $urandom_range(0, 3);
      apply_settings(spd, $urandom_range(0, 1), $urandom_range(0, 1), chn, frm);
      sender_steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 85) send_item(CMD_RESTART, rand_word(), rand_word());
      len = $urandom_range(40, 120);
      for (n = 0; n < len && items_sent < item_goal; n++) begin
         r = $urandom_range(0, 99);
         if (r < 62) play_frame();
         else if (r < 74) send_item(CMD_WRITE, board.sound_word($urandom), pick_sample());
         else if (r < 80) send_item(CMD_WRITE, rand_word(), pick_sample());
         else if (r < 87) send_item(CMD_RESTART, rand_word(), rand_word());
         else if (r < 91) send_item(CMD_UNUSED, rand_word(), rand_word());
         else if (r < 93) begin
            drain();   // hold off until every sample item is out
            play_frame();
         end
         else play_frame();
      end
   endtask

   initial begin : result_pacing
      int unsigned hold, stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_bus.ready <= 1'b1;
         hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
         repeat (hold) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : watch_results
      out_sample_t got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.sample_out, rsp_bus.channel_index, rsp_bus.last_of_frame,
                 rsp_bus.finished};
         board.check_sample(got);
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("pitch_shift_sample_player_top test failed");
      $finish;
   end

   initial begin : stimulus
      board = new();
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.command      <= CMD_WRITE;
      req_bus.sample_addr  <= '0;
      req_bus.sample_value <= '0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_part();
      item_goal = items_sent + RANDOM_ITEMS;
      while (items_sent < item_goal) random_phase();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.due_samples.size() == 0)
         $display("pitch_shift_sample_player_top test passed");
      else
         $display("pitch_shift_sample_player_top test failed");
      $finish;
   end
endmodule
